// File: hw/rtl/r2sr_pkg.sv
// r2sr_pkg: shared types and constants for the R2 score reduction block.
// Used by r2sr_front, r2sr_fifo, r2sr_back and r2_score_reduce; no dependencies.

package r2sr_pkg;

   localparam int DEF_MAX_SAMPLES = 4096;
   localparam int DEF_QUEUE_DEPTH = 4;

   localparam int SAMPLE_W = 16;
   localparam int R2_W     = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 13;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FLAT = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVF  = 2'd2;

   localparam logic signed [R2_W-1:0] R2_ONE = 32'sd65536;
   localparam logic signed [R2_W-1:0] R2_MIN = 32'sh8000_0000;
   localparam logic [COUNT_W-1:0]     COUNT_SAT = 13'h1fff;

   // One queued transaction, classified by the front end
   typedef struct packed {
      logic [SAMPLE_W-1:0] truth;
      logic [SAMPLE_W-1:0] pred;
      logic                keep;
      logic                last;
   } r2sr_entry_type;

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_LOAD,
      ST_MUL_A,
      ST_MUL_B,
      ST_MUL_N,
      ST_DIV,
      ST_EMIT
   } r2sr_state_type;

endpackage

// File: hw/rtl/r2_score_reduce.sv
// r2_score_reduce: top level of the streaming R2 score block.
// Instantiates r2sr_front, r2sr_fifo and r2sr_back; uses r2sr_pkg.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_stall | true_value, predicted_value, last
//   rsp     | out       | rsp_valid / rsp_stall | r2_value, status, sample_count
//
// A pair is taken every cycle while the queue has room; the back end
// squares and accumulates each pair while no result is being computed.
// The last pair of a set starts the sequential shift-add multiplier and
// the one-bit-per-cycle restoring divider. Pairs keep queuing meanwhile
// until the queue is full.
// Reset is synchronous and clears the queue, the sums and the result valid flag.
// rsp_stall holds the result register; req_stall rises only when the queue is full.

module r2_score_reduce
   import r2sr_pkg::*;
#(
   parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_true_value,
   input  logic signed [SAMPLE_W-1:0] req_predicted_value,
   input  logic                       req_last,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [R2_W-1:0]     rsp_r2_value,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [COUNT_W-1:0]         rsp_sample_count
);

   r2sr_entry_type push_entry, head_entry;
   logic           fifo_push, fifo_pop, fifo_full, fifo_empty;

   r2sr_front #(
      .MAX_SAMPLES(MAX_SAMPLES)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_true_value     (req_true_value),
      .req_predicted_value(req_predicted_value),
      .req_last           (req_last),
      .queue_full         (fifo_full),
      .queue_push         (fifo_push),
      .queue_entry        (push_entry)
   );

   r2sr_fifo #(
      .DEPTH(QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (fifo_push),
      .push_data(push_entry),
      .pop      (fifo_pop),
      .head     (head_entry),
      .full     (fifo_full),
      .empty    (fifo_empty)
   );

   r2sr_back #(
      .MAX_SAMPLES(MAX_SAMPLES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_head      (head_entry),
      .queue_empty     (fifo_empty),
      .queue_pop       (fifo_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_r2_value    (rsp_r2_value),
      .rsp_status      (rsp_status),
      .rsp_sample_count(rsp_sample_count)
   );

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      fifo_full |-> !fifo_push)
      else $error("queue push while full");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      fifo_pop |-> !fifo_empty)
      else $error("queue pop while empty");

   a_r2_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_r2_value <= R2_ONE))
      else $error("R2 above one");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sample_count != '0))
      else $error("result with empty set");
`endif

endmodule

// File: hw/rtl/r2sr_front.sv
// r2sr_front: accepts input transactions, tracks the set fill level and
// marks pairs beyond the sample limit as dropped. Depends on r2sr_pkg.

module r2sr_front
   import r2sr_pkg::*;
#(
   parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
)(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_true_value,
   input  logic signed [SAMPLE_W-1:0] req_predicted_value,
   input  logic                       req_last,
   input  logic                       queue_full,
   output logic                       queue_push,
   output r2sr_entry_type             queue_entry
);

   localparam int CW = $clog2(MAX_SAMPLES + 1);
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SAMPLES);

   logic [CW-1:0] cnt_ff, cnt_in;
   logic          keep;

   assign req_stall  = queue_full;
   assign queue_push = req_valid & ~queue_full;
   assign keep       = (cnt_ff != CNT_MAX);

   assign queue_entry.truth = req_true_value;
   assign queue_entry.pred  = req_predicted_value;
   assign queue_entry.keep  = keep;
   assign queue_entry.last  = req_last;

   always_comb begin
      cnt_in = cnt_ff;
      if (queue_push) begin
         if (req_last) begin
            cnt_in = '0;
         end else if (keep) begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

// File: hw/rtl/r2sr_fifo.sv
// r2sr_fifo: short queue of classified transactions between front and back.
// Depends on r2sr_pkg for the entry type.

module r2sr_fifo
   import r2sr_pkg::*;
#(
   parameter int DEPTH = DEF_QUEUE_DEPTH
)(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  r2sr_entry_type push_data,
   input  logic           pop,
   output r2sr_entry_type head,
   output logic           full,
   output logic           empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LVL_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [LVL_W-1:0] FULL_LVL = LVL_W'(DEPTH);

   r2sr_entry_type    slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0]  level_ff, level_in;

   assign full  = (level_ff == FULL_LVL);
   assign empty = (level_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   level_in = level_ff + 1'b1;
         2'b01:   level_in = level_ff - 1'b1;
         default: level_in = level_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

endmodule

// File: hw/rtl/r2sr_back.sv
// r2sr_back: squares and accumulates queued pairs, then on the last pair of a
// set runs a shift-add multiplier and restoring divider to form R2. Uses r2sr_pkg.

module r2sr_back
   import r2sr_pkg::*;
#(
   parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
)(
   input  logic                       clock,
   input  logic                       reset,
   input  r2sr_entry_type             queue_head,
   input  logic                       queue_empty,
   output logic                       queue_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [R2_W-1:0]     rsp_r2_value,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [COUNT_W-1:0]         rsp_sample_count
);

   localparam int LG  = $clog2(MAX_SAMPLES);
   localparam int CW  = $clog2(MAX_SAMPLES + 1);
   localparam int SW  = 17 + LG;
   localparam int AW  = SW - 1;
   localparam int T2W = 31 + LG;
   localparam int RW  = 32 + LG;
   localparam int MB  = AW;
   localparam int PW  = RW + AW;
   localparam int DW  = CW + T2W;
   localparam int NW  = CW + RW + 16;
   localparam int DCW = $clog2(NW + 1);

   r2sr_state_type state_ff, state_in;

   // square stage
   logic                stg_valid_ff, stg_valid_in;
   logic                stg_keep_ff, stg_last_ff;
   logic [SAMPLE_W-1:0] stg_truth_ff;
   logic [30:0]         stg_t2_ff;
   logic [31:0]         stg_r2_ff;

   // running sums
   logic [SW-1:0]  sum_t_ff, sum_t_in;
   logic [T2W-1:0] sum_t2_ff, sum_t2_in;
   logic [RW-1:0]  sum_r2_ff, sum_r2_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           ovf_ff, ovf_in;

   // multiply / divide unit
   logic [PW-1:0]  prod_ff, prod_in;
   logic [PW-1:0]  mcand_ff, mcand_in;
   logic [MB-1:0]  mplier_ff, mplier_in;
   logic [DW-1:0]  dval_ff, dval_in;
   logic [DW-1:0]  rem_ff, rem_in;
   logic [NW-1:0]  num_ff, num_in;
   logic [DCW-1:0] dcnt_ff, dcnt_in;

   // result register
   logic                    out_valid_ff, out_valid_in;
   logic signed [R2_W-1:0]  out_r2_ff, out_r2_in;
   logic [STATUS_W-1:0]     out_status_ff, out_status_in;
   logic [COUNT_W-1:0]      out_count_ff, out_count_in;

   logic               stg_take, out_free, emit, mul_done;
   logic signed [16:0] diff;
   logic signed [31:0] t_sq;
   logic signed [33:0] r_sq;
   logic [SW-1:0]      neg_sum, abs_full;
   logic [AW-1:0]      abs_s;
   logic [DW:0]        rem_sh, rem_sub;
   logic               rem_ge;
   logic [33:0]        q_low;
   logic               q_big;
   logic signed [33:0] r2_wide;
   logic signed [R2_W-1:0] r2_div;
   logic [31:0]        cnt_wide;

   assign mul_done = (mplier_ff == '0);
   assign out_free = ~out_valid_ff | ~rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_ACCUM: if (stg_valid_ff && stg_last_ff) state_in = ST_LOAD;
         ST_LOAD:  state_in = ST_MUL_A;
         ST_MUL_A: if (mul_done) state_in = ST_MUL_B;
         ST_MUL_B: if (mul_done) state_in = ST_MUL_N;
         ST_MUL_N: begin
            if (mul_done) state_in = (dval_ff == '0) ? ST_EMIT : ST_DIV;
         end
         ST_DIV:   if (dcnt_ff == DCW'(1)) state_in = ST_EMIT;
         ST_EMIT:  if (out_free) state_in = ST_ACCUM;
         default:  state_in = ST_ACCUM;
      endcase
   end

   // state outputs
   always_comb begin
      stg_take  = stg_valid_ff & (state_ff == ST_ACCUM);
      emit      = (state_ff == ST_EMIT) & out_free;
      queue_pop = ~queue_empty & (~stg_valid_ff | stg_take);
   end

   assign diff = $signed({queue_head.truth[15], queue_head.truth})
               - $signed({queue_head.pred[15], queue_head.pred});
   assign t_sq = $signed(queue_head.truth) * $signed(queue_head.truth);
   assign r_sq = diff * diff;

   assign neg_sum  = -sum_t_ff;
   assign abs_full = sum_t_ff[SW-1] ? neg_sum : sum_t_ff;
   assign abs_s    = abs_full[AW-1:0];

   assign rem_sh  = {rem_ff, num_ff[NW-1]};
   assign rem_sub = rem_sh - {1'b0, dval_ff};
   assign rem_ge  = (rem_sh >= {1'b0, dval_ff});

   assign q_low   = {1'b0, num_ff[32:0]};
   assign q_big   = |num_ff[NW-1:33];
   assign r2_wide = 34'sd65536 - $signed(q_low);
   assign r2_div  = (q_big || (r2_wide < -34'sd2147483648)) ? R2_MIN : r2_wide[31:0];
   assign cnt_wide = 32'(cnt_ff);

   always_comb begin
      stg_valid_in = queue_pop ? 1'b1 : (stg_take ? 1'b0 : stg_valid_ff);

      sum_t_in  = sum_t_ff;
      sum_t2_in = sum_t2_ff;
      sum_r2_in = sum_r2_ff;
      cnt_in    = cnt_ff;
      ovf_in    = ovf_ff;
      if (emit) begin
         sum_t_in  = '0;
         sum_t2_in = '0;
         sum_r2_in = '0;
         cnt_in    = '0;
         ovf_in    = 1'b0;
      end else if (stg_take) begin
         if (stg_keep_ff) begin
            sum_t_in  = sum_t_ff + {{(SW-SAMPLE_W){stg_truth_ff[15]}}, stg_truth_ff};
            sum_t2_in = sum_t2_ff + T2W'(stg_t2_ff);
            sum_r2_in = sum_r2_ff + RW'(stg_r2_ff);
            cnt_in    = cnt_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end

      prod_in   = prod_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      dval_in   = dval_ff;
      rem_in    = rem_ff;
      num_in    = num_ff;
      dcnt_in   = dcnt_ff;
      unique case (state_ff)
         ST_LOAD: begin
            prod_in   = '0;
            mcand_in  = PW'(sum_t2_ff);
            mplier_in = MB'(cnt_ff);
         end
         ST_MUL_A, ST_MUL_B, ST_MUL_N: begin
            if (!mul_done) begin
               if (mplier_ff[0]) prod_in = prod_ff + mcand_ff;
               mcand_in  = {mcand_ff[PW-2:0], 1'b0};
               mplier_in = {1'b0, mplier_ff[MB-1:1]};
            end else if (state_ff == ST_MUL_A) begin
               dval_in   = prod_ff[DW-1:0];
               prod_in   = '0;
               mcand_in  = PW'(abs_s);
               mplier_in = abs_s;
            end else if (state_ff == ST_MUL_B) begin
               dval_in   = dval_ff - prod_ff[DW-1:0];
               prod_in   = '0;
               mcand_in  = PW'(sum_r2_ff);
               mplier_in = MB'(cnt_ff);
            end else begin
               num_in  = {prod_ff[CW+RW-1:0], 16'd0};
               rem_in  = '0;
               dcnt_in = DCW'(NW);
            end
         end
         ST_DIV: begin
            rem_in  = rem_ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            num_in  = {num_ff[NW-2:0], rem_ge};
            dcnt_in = dcnt_ff - 1'b1;
         end
         default: begin
         end
      endcase

      out_valid_in  = out_valid_ff & rsp_stall;
      out_r2_in     = out_r2_ff;
      out_status_in = out_status_ff;
      out_count_in  = out_count_ff;
      if (emit) begin
         out_valid_in  = 1'b1;
         out_status_in = STATUS_OK;
         if (dval_ff != '0) begin
            out_r2_in = r2_div;
         end else if (sum_r2_ff == '0) begin
            out_r2_in = R2_ONE;
         end else begin
            out_r2_in     = R2_MIN;
            out_status_in = STATUS_FLAT;
         end
         if (ovf_ff) out_status_in = STATUS_OVF;
         out_count_in = (cnt_wide > 32'd8191) ? COUNT_SAT : cnt_wide[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         stg_valid_ff <= 1'b0;
         sum_t_ff     <= '0;
         sum_t2_ff    <= '0;
         sum_r2_ff    <= '0;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stg_valid_ff <= stg_valid_in;
         sum_t_ff     <= sum_t_in;
         sum_t2_ff    <= sum_t2_in;
         sum_r2_ff    <= sum_r2_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         stg_keep_ff  <= queue_head.keep;
         stg_last_ff  <= queue_head.last;
         stg_truth_ff <= queue_head.truth;
         stg_t2_ff    <= t_sq[30:0];
         stg_r2_ff    <= r_sq[31:0];
      end
      prod_ff       <= prod_in;
      mcand_ff      <= mcand_in;
      mplier_ff     <= mplier_in;
      dval_ff       <= dval_in;
      rem_ff        <= rem_in;
      num_ff        <= num_in;
      dcnt_ff       <= dcnt_in;
      out_r2_ff     <= out_r2_in;
      out_status_ff <= out_status_in;
      out_count_ff  <= out_count_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_r2_value     = out_r2_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_sample_count = out_count_ff;

endmodule
